>>> hw/rtl/lct_pkg.sv
`timescale 1ns / 1ps

package lct_pkg;

    localparam int ENTRIES_DEFAULT    = 16;
    localparam int KEY_BITS_DEFAULT   = 32;
    localparam int VALUE_BITS_DEFAULT = 32;

    localparam int CAP_BITS   = 5;
    localparam int KIND_BITS  = 2;
    localparam int COUNT_BITS = 32;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

endpackage

>>> hw/rtl/lru_cache_table.sv
`timescale 1ns / 1ps

// Channel   Direction  tuser               tdata (lowest bits first)
// s_        in         kind                key, write_value
// m_        out        hit                 read_value, occupancy, hit_count, miss_count
// cfg_      in         -                   capacity_in_use (cfg_wdata, written when cfg_we)
//
// One transaction per cycle is taken and one result per cycle is delivered while the
// result is not stalled. A request passes through the input stage and then the result
// register; the parallel tag compare and age update between them are combinational.
// Reset clears valid bits, ages, occupancy and both counters at once; no clearing pass.
// A stalled result holds the result register, and the input stage then holds one request.
module lru_cache_table #(
    parameter int ENTRIES    = lct_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS   = lct_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS = lct_pkg::VALUE_BITS_DEFAULT,
    localparam int OCC_W     = $clog2(ENTRIES + 1),
    localparam int S_TDATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((VALUE_BITS + OCC_W + 2 * lct_pkg::COUNT_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [lct_pkg::CAP_BITS-1:0]  cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,   // key, write_value
    input  logic [lct_pkg::KIND_BITS-1:0] s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_TDATA_W-1:0]          m_tdata,   // read_value, occupancy, hit_count,
                                                     // miss_count
    output logic                          m_tuser    // hit
);
    import lct_pkg::*;

    localparam int AGE_W = $clog2(ENTRIES);
    localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

    // Table state
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [AGE_W-1:0]      age_reg   [ENTRIES];
    logic [AGE_W-1:0]      age_next  [ENTRIES];
    logic [OCC_W-1:0]      count_reg, count_next;
    logic [COUNT_BITS-1:0] hit_cnt_reg, hit_cnt_next;
    logic [COUNT_BITS-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CAP_BITS-1:0]   cap_reg;

    // Input stage
    logic                  stg_valid_reg;
    logic [KIND_BITS-1:0]  stg_kind_reg;
    logic [KEY_BITS-1:0]   stg_key_reg;
    logic [VALUE_BITS-1:0] stg_value_reg;

    // Result register
    logic                  out_valid_reg;
    logic                  out_hit_reg, out_hit_next;
    logic [VALUE_BITS-1:0] out_read_reg, out_read_next;
    logic [OCC_W-1:0]      out_occ_reg;
    logic [COUNT_BITS-1:0] out_hits_reg, out_misses_reg;

    logic                  advance, do_item, s_accept;
    logic [ENTRIES-1:0]    match, victim, kept, free_slots, slot;
    logic [ENTRIES-1:0]    key_we, value_we;
    logic                  hit_any, full;
    logic [VALUE_BITS-1:0] hit_value;
    logic [AGE_W-1:0]      hit_age, oldest_age;
    logic [CMP_W-1:0]      cap_ext, cap_eff;

    assign advance  = !out_valid_reg || m_tready;
    assign do_item  = stg_valid_reg && advance;
    assign s_tready = !stg_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
        full = CMP_W'(count_reg) >= cap_eff;
    end

    // Valid entries always carry the distinct ages 0 .. count-1, so the least
    // recent one is simply the entry whose age equals count-1.
    always_comb begin
        oldest_age = AGE_W'(count_reg - 1'b1);
        hit_value  = '0;
        hit_age    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]  = valid_reg[i] && (key_reg[i] == stg_key_reg);
            victim[i] = valid_reg[i] && (age_reg[i] == oldest_age);
            hit_value = hit_value | (match[i] ? value_reg[i] : '0);
            hit_age   = hit_age | (match[i] ? age_reg[i] : '0);
        end
        hit_any    = |match;
        kept       = full ? (valid_reg & ~victim) : valid_reg;
        free_slots = ~kept;
        slot       = free_slots & (~free_slots + 1'b1);
    end

    always_comb begin
        valid_next    = valid_reg;
        age_next      = age_reg;
        count_next    = count_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        key_we        = '0;
        value_we      = '0;
        if (do_item) begin
            case (kind_t'(stg_kind_reg))
                KIND_LOOKUP, KIND_INSERT: begin
                    if (hit_any) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (match[i]) begin
                                age_next[i] = '0;
                            end else if (valid_reg[i] && (age_reg[i] < hit_age)) begin
                                age_next[i] = age_reg[i] + 1'b1;
                            end
                        end
                        if (kind_t'(stg_kind_reg) == KIND_LOOKUP) begin
                            if (hit_cnt_reg != '1) begin
                                hit_cnt_next = hit_cnt_reg + 1'b1;
                            end
                        end else begin
                            value_we = match;
                        end
                    end else if (kind_t'(stg_kind_reg) == KIND_LOOKUP) begin
                        if (miss_cnt_reg != '1) begin
                            miss_cnt_next = miss_cnt_reg + 1'b1;
                        end
                    end else begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (kept[i]) begin
                                age_next[i] = age_reg[i] + 1'b1;
                            end else begin
                                age_next[i] = '0;
                            end
                        end
                        valid_next = kept | slot;
                        key_we     = slot;
                        value_we   = slot;
                        count_next = count_reg + 1'b1 - OCC_W'(full);
                    end
                end
                KIND_CLEAR: begin
                    hit_cnt_next  = '0;
                    miss_cnt_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_hit_next  = hit_any && (stg_kind_reg inside {KIND_LOOKUP, KIND_INSERT});
        out_read_next = (hit_any && (kind_t'(stg_kind_reg) == KIND_LOOKUP)) ? hit_value : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            cap_reg       <= CAP_RESET;
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            age_reg      <= age_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (s_accept) begin
                stg_valid_reg <= 1'b1;
            end else if (do_item) begin
                stg_valid_reg <= 1'b0;
            end
            if (do_item) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (key_we[i]) begin
                key_reg[i] <= stg_key_reg;
            end
            if (value_we[i]) begin
                value_reg[i] <= stg_value_reg;
            end
        end
        if (s_accept) begin
            stg_kind_reg  <= s_tuser;
            stg_key_reg   <= s_tdata[KEY_BITS-1:0];
            stg_value_reg <= s_tdata[KEY_BITS +: VALUE_BITS];
        end
        if (do_item) begin
            out_hit_reg    <= out_hit_next;
            out_read_reg   <= out_read_next;
            out_occ_reg    <= count_next;
            out_hits_reg   <= hit_cnt_next;
            out_misses_reg <= miss_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = M_TDATA_W'({out_misses_reg, out_hits_reg, out_occ_reg, out_read_reg});

    a_count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("occupancy does not match the number of valid entries");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= ENTRIES)
        else $error("occupancy exceeds the table depth");

    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid_reg |-> $onehot0(match))
        else $error("a key matches more than one valid entry");

    a_blocked_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (stg_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while the stage is held by a stalled result");

    a_insert_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_item && (kind_t'(stg_kind_reg) == KIND_INSERT) && !hit_any) |-> $onehot(slot))
        else $error("no free entry for a new key");

endmodule
